// ===== rtl/tcd_pkg.sv =====
// Shared widths, register indexes and payload types of the triangle coverage and depth block.
package tcd_pkg;

    localparam int SCREEN_BITS_DEF = 11;

    localparam int DIFF_W  = 17;
    localparam int PROD_W  = 34;
    localparam int AREA_W  = 35;
    localparam int E_W     = 38;
    localparam int PP_W    = 32;
    localparam int T_W     = 70;
    localparam int S_W     = 72;
    localparam int M_W     = 87;
    localparam int NUM_W   = 89;
    localparam int DEN_W   = 72;
    localparam int CNUM_W  = T_W + 14;
    localparam int DNUM_W  = NUM_W;
    localparam int DIV_QB  = 16;

    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_VERTEX0 = 2'd0;
    localparam cfg_idx_t REG_VERTEX1 = 2'd1;
    localparam cfg_idx_t REG_VERTEX2 = 2'd2;

    typedef struct packed {
        logic [15:0] w;
        logic [15:0] z;
        logic [15:0] y;
        logic [15:0] x;
    } vert_t;

    typedef struct packed {
        logic signed [E_W-1:0] e0;
        logic signed [E_W-1:0] e1;
        logic signed [E_W-1:0] e2;
        logic [PP_W-1:0]       pp0;
        logic [PP_W-1:0]       pp1;
        logic [PP_W-1:0]       pp2;
        logic [15:0]           z0;
        logic [15:0]           z1;
        logic [15:0]           z2;
        logic                  cov;
        logic                  degen;
    } edge_res_t;

    typedef struct packed {
        logic [DEN_W-1:0]  den;
        logic [CNUM_W-1:0] cnum0;
        logic [CNUM_W-1:0] cnum1;
        logic [CNUM_W-1:0] cnum2;
        logic [DNUM_W-1:0] dnum;
        logic [2:0]        cneg;
        logic              dneg;
        logic              szero;
        logic              cov;
        logic              degen;
    } div_in_t;

endpackage

// ===== rtl/tcd_edge.sv =====
// Edge function stages: pixel centre, edge products, edge values and coverage.
module tcd_edge #(
    parameter int SCREEN_BITS = tcd_pkg::SCREEN_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [SCREEN_BITS-1:0]  pixel_x,
    input  logic [SCREEN_BITS-1:0]  pixel_y,
    input  tcd_pkg::vert_t          vert0,
    input  tcd_pkg::vert_t          vert1,
    input  tcd_pkg::vert_t          vert2,
    output logic                    out_valid,
    output tcd_pkg::edge_res_t      res
);

    localparam int DW = tcd_pkg::DIFF_W;
    localparam int PW = tcd_pkg::PROD_W;
    localparam int AW = tcd_pkg::AREA_W;
    localparam int EW = tcd_pkg::E_W;

    logic signed [DW-1:0] px, py;
    logic signed [DW-1:0] vx0, vx1, vx2, vy0, vy1, vy2;

    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic signed [DW-1:0] a_reg, b_reg, c_reg, d_reg, f_reg, g_reg;
    logic signed [DW-1:0] ax_reg, ay_reg, by_reg, bx_reg;
    logic [15:0] w0_reg, w1_reg, w2_reg;
    logic [15:0] z0_s1_reg, z1_s1_reg, z2_s1_reg;

    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic [tcd_pkg::PP_W-1:0] pp0_s2_reg, pp1_s2_reg, pp2_s2_reg;
    logic [15:0] z0_s2_reg, z1_s2_reg, z2_s2_reg;

    logic signed [AW-1:0] e0_reg, e1_reg, area_reg;
    logic [tcd_pkg::PP_W-1:0] pp0_s3_reg, pp1_s3_reg, pp2_s3_reg;
    logic [15:0] z0_s3_reg, z1_s3_reg, z2_s3_reg;

    logic signed [EW-1:0] e0_ext, e1_ext, e2_next;
    logic degen_next, cov_next;
    tcd_pkg::edge_res_t res_reg;

    // Pixel centre in 12.4 units is the pixel index times 16 plus one half.
    assign px = DW'({pixel_x, 4'h8});
    assign py = DW'({pixel_y, 4'h8});
    assign vx0 = DW'({1'b0, vert0.x});
    assign vx1 = DW'({1'b0, vert1.x});
    assign vx2 = DW'({1'b0, vert2.x});
    assign vy0 = DW'({1'b0, vert0.y});
    assign vy1 = DW'({1'b0, vert1.y});
    assign vy2 = DW'({1'b0, vert2.y});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= vx1 - px;
        b_reg  <= vy2 - py;
        c_reg  <= vy1 - py;
        d_reg  <= vx2 - px;
        f_reg  <= vx0 - px;
        g_reg  <= vy0 - py;
        ax_reg <= vx1 - vx0;
        ay_reg <= vy2 - vy0;
        by_reg <= vy1 - vy0;
        bx_reg <= vx2 - vx0;
        // A clip w of zero is taken as the smallest step, 1/256.
        w0_reg <= (vert0.w == 16'd0) ? 16'd1 : vert0.w;
        w1_reg <= (vert1.w == 16'd0) ? 16'd1 : vert1.w;
        w2_reg <= (vert2.w == 16'd0) ? 16'd1 : vert2.w;
        z0_s1_reg <= vert0.z;
        z1_s1_reg <= vert1.z;
        z2_s1_reg <= vert2.z;
    end

    always_ff @(posedge clk)
    begin
        p0_reg <= PW'(a_reg) * PW'(b_reg);
        p1_reg <= PW'(c_reg) * PW'(d_reg);
        p2_reg <= PW'(d_reg) * PW'(g_reg);
        p3_reg <= PW'(b_reg) * PW'(f_reg);
        p4_reg <= PW'(ax_reg) * PW'(ay_reg);
        p5_reg <= PW'(by_reg) * PW'(bx_reg);
        pp0_s2_reg <= tcd_pkg::PP_W'(w1_reg) * tcd_pkg::PP_W'(w2_reg);
        pp1_s2_reg <= tcd_pkg::PP_W'(w0_reg) * tcd_pkg::PP_W'(w2_reg);
        pp2_s2_reg <= tcd_pkg::PP_W'(w0_reg) * tcd_pkg::PP_W'(w1_reg);
        z0_s2_reg <= z0_s1_reg;
        z1_s2_reg <= z1_s1_reg;
        z2_s2_reg <= z2_s1_reg;
    end

    always_ff @(posedge clk)
    begin
        e0_reg   <= AW'(p0_reg) - AW'(p1_reg);
        e1_reg   <= AW'(p2_reg) - AW'(p3_reg);
        area_reg <= AW'(p4_reg) - AW'(p5_reg);
        pp0_s3_reg <= pp0_s2_reg;
        pp1_s3_reg <= pp1_s2_reg;
        pp2_s3_reg <= pp2_s2_reg;
        z0_s3_reg <= z0_s2_reg;
        z1_s3_reg <= z1_s2_reg;
        z2_s3_reg <= z2_s2_reg;
    end

    always_comb
    begin
        e0_ext     = EW'(e0_reg);
        e1_ext     = EW'(e1_reg);
        e2_next    = EW'(area_reg) - e0_ext - e1_ext;
        degen_next = (area_reg == '0);
        if (area_reg > 0)
            cov_next = (e0_ext >= 0) && (e1_ext >= 0) && (e2_next >= 0);
        else
            cov_next = (e0_ext <= 0) && (e1_ext <= 0) && (e2_next <= 0);
    end

    always_ff @(posedge clk)
    begin
        // A zero-area triangle gives equal weights of one third each.
        res_reg.e0    <= degen_next ? EW'(1) : e0_ext;
        res_reg.e1    <= degen_next ? EW'(1) : e1_ext;
        res_reg.e2    <= degen_next ? EW'(1) : e2_next;
        res_reg.cov   <= degen_next | cov_next;
        res_reg.degen <= degen_next;
        res_reg.pp0   <= pp0_s3_reg;
        res_reg.pp1   <= pp1_s3_reg;
        res_reg.pp2   <= pp2_s3_reg;
        res_reg.z0    <= z0_s3_reg;
        res_reg.z1    <= z1_s3_reg;
        res_reg.z2    <= z2_s3_reg;
    end

    assign out_valid = v4_reg;
    assign res       = res_reg;

endmodule

// ===== rtl/tcd_weight.sv =====
// Weight stages: weighted edge terms, their sums and the divider operands.
module tcd_weight (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  tcd_pkg::edge_res_t  res,
    output logic                out_valid,
    output tcd_pkg::div_in_t    dop
);

    localparam int TW = tcd_pkg::T_W;
    localparam int SW = tcd_pkg::S_W;
    localparam int MW = tcd_pkg::M_W;
    localparam int NW = tcd_pkg::NUM_W;

    logic v5_reg, v6_reg, v7_reg, v8_reg;

    logic signed [TW-1:0] t0_reg, t1_reg, t2_reg;
    logic [15:0] z0_reg, z1_reg, z2_reg;
    logic cov5_reg, degen5_reg;

    logic signed [TW-1:0] t0_s6_reg, t1_s6_reg, t2_s6_reg;
    logic signed [SW-1:0] s_reg;
    logic signed [MW-1:0] m0_reg, m1_reg, m2_reg;
    logic cov6_reg, degen6_reg;

    logic signed [TW-1:0] t0_s7_reg, t1_s7_reg, t2_s7_reg;
    logic signed [SW-1:0] s_s7_reg;
    logic signed [NW-1:0] num_reg;
    logic cov7_reg, degen7_reg;

    logic [TW-1:0] tm0, tm1, tm2;
    logic s_neg;
    tcd_pkg::div_in_t dop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= in_valid;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t0_reg <= TW'(res.e0) * TW'($signed({1'b0, res.pp0}));
        t1_reg <= TW'(res.e1) * TW'($signed({1'b0, res.pp1}));
        t2_reg <= TW'(res.e2) * TW'($signed({1'b0, res.pp2}));
        z0_reg <= res.z0;
        z1_reg <= res.z1;
        z2_reg <= res.z2;
        cov5_reg   <= res.cov;
        degen5_reg <= res.degen;
    end

    always_ff @(posedge clk)
    begin
        s_reg  <= SW'(t0_reg) + SW'(t1_reg) + SW'(t2_reg);
        m0_reg <= MW'(t0_reg) * MW'($signed({1'b0, z0_reg}));
        m1_reg <= MW'(t1_reg) * MW'($signed({1'b0, z1_reg}));
        m2_reg <= MW'(t2_reg) * MW'($signed({1'b0, z2_reg}));
        t0_s6_reg <= t0_reg;
        t1_s6_reg <= t1_reg;
        t2_s6_reg <= t2_reg;
        cov6_reg   <= cov5_reg;
        degen6_reg <= degen5_reg;
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= NW'(m0_reg) + NW'(m1_reg) + NW'(m2_reg);
        s_s7_reg  <= s_reg;
        t0_s7_reg <= t0_s6_reg;
        t1_s7_reg <= t1_s6_reg;
        t2_s7_reg <= t2_s6_reg;
        cov7_reg   <= cov6_reg;
        degen7_reg <= degen6_reg;
    end

    // The dividers work on magnitudes; the signs travel beside them.
    always_comb
    begin
        s_neg = s_s7_reg[SW-1];
        tm0   = t0_s7_reg[TW-1] ? TW'(-t0_s7_reg) : TW'(t0_s7_reg);
        tm1   = t1_s7_reg[TW-1] ? TW'(-t1_s7_reg) : TW'(t1_s7_reg);
        tm2   = t2_s7_reg[TW-1] ? TW'(-t2_s7_reg) : TW'(t2_s7_reg);
    end

    always_ff @(posedge clk)
    begin
        dop_reg.den     <= s_neg ? tcd_pkg::DEN_W'(-s_s7_reg) : tcd_pkg::DEN_W'(s_s7_reg);
        dop_reg.cnum0   <= {tm0, 14'd0};
        dop_reg.cnum1   <= {tm1, 14'd0};
        dop_reg.cnum2   <= {tm2, 14'd0};
        dop_reg.dnum    <= num_reg[NW-1] ? tcd_pkg::DNUM_W'(-num_reg)
                                         : tcd_pkg::DNUM_W'(num_reg);
        dop_reg.cneg[0] <= t0_s7_reg[TW-1] ^ s_neg;
        dop_reg.cneg[1] <= t1_s7_reg[TW-1] ^ s_neg;
        dop_reg.cneg[2] <= t2_s7_reg[TW-1] ^ s_neg;
        dop_reg.dneg    <= num_reg[NW-1] ^ s_neg;
        dop_reg.szero   <= (s_s7_reg == '0);
        dop_reg.cov     <= cov7_reg;
        dop_reg.degen   <= degen7_reg;
    end

    assign out_valid = v8_reg;
    assign dop       = dop_reg;

endmodule

// ===== rtl/tcd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with an overflow flag.
module tcd_div #(
    parameter int NW = tcd_pkg::DNUM_W,
    parameter int DW = tcd_pkg::DEN_W,
    parameter int QB = tcd_pkg::DIV_QB
) (
    input  logic          clk,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QB-1:0] quo,
    output logic          ovf
);

    localparam int CW = (NW > DW + QB) ? NW : DW + QB;

    logic [CW-1:0] rem_reg [0:QB];
    logic [DW-1:0] den_reg [0:QB];
    logic [QB-1:0] q_reg   [0:QB];
    logic          ovf_reg [0:QB];

    // The first stage flags a quotient too large for QB bits; no quotient bit is set then.
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= CW'(num);
        den_reg[0] <= den;
        q_reg[0]   <= '0;
        ovf_reg[0] <= CW'(num) >= (CW'(den) << QB);
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_stage
        localparam int B = QB - k;
        logic [CW-1:0] trial;
        logic          hit;

        always_comb
        begin
            trial = CW'(den_reg[k-1]) << B;
            hit   = !ovf_reg[k-1] && (rem_reg[k-1] >= trial);
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= hit ? rem_reg[k-1] - trial : rem_reg[k-1];
            den_reg[k] <= den_reg[k-1];
            q_reg[k]   <= hit ? (q_reg[k-1] | (QB'(1) << B)) : q_reg[k-1];
            ovf_reg[k] <= ovf_reg[k-1];
        end
    end

    assign quo = q_reg[QB];
    assign ovf = ovf_reg[QB];

endmodule

// ===== rtl/triangle_coverage_depth_top.sv =====
// Top level of the triangle coverage and perspective-correct depth pipeline.
//
//  Channel   Signals                                 Transfer
//  -------   -------------------------------------   ----------------------------------
//  config    cfg_valid cfg_ready cfg_index cfg_data  cfg_valid && cfg_ready
//  pixel     start busy pixel_x pixel_y              start && !busy
//  result    done covered degenerate frag_depth      done high for one cycle
//            corr_weight0 corr_weight1 corr_weight2
//
// One pixel transaction is taken every cycle; busy is always low and cfg_ready always high.
// Each result passes the edge stages, the weight stages, the divider stages (an overflow
// check, then one quotient bit per stage) and the output register.
// Reset clears the vertex registers, all valid bits and the divider side flags; the rest of the data path has no reset.
// The result side cannot stall, so the pipeline never holds.
module triangle_coverage_depth_top #(
    parameter int SCREEN_BITS = tcd_pkg::SCREEN_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [tcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                cfg_data,
    input  logic                       start,
    output logic                       busy,
    input  logic [SCREEN_BITS-1:0]     pixel_x,
    input  logic [SCREEN_BITS-1:0]     pixel_y,
    output logic                       done,
    output logic                       covered,
    output logic                       degenerate,
    output logic [15:0]                frag_depth,
    output logic signed [15:0]         corr_weight0,
    output logic signed [15:0]         corr_weight1,
    output logic signed [15:0]         corr_weight2
);

    localparam int QB      = tcd_pkg::DIV_QB;
    localparam int DIV_LAT = QB + 1;

    typedef struct packed {
        logic       valid;
        logic       cov;
        logic       degen;
        logic       szero;
        logic [2:0] cneg;
        logic       dneg;
    } side_t;

    logic [63:0] vertex0_reg, vertex1_reg, vertex2_reg;

    logic               edge_valid, div_valid;
    tcd_pkg::edge_res_t edge_res;
    tcd_pkg::div_in_t   dop;

    logic [QB-1:0] q0, q1, q2, qd;
    logic          o0, o1, o2, od;

    side_t sb_reg [0:DIV_LAT-1];

    logic               done_reg, covered_reg, degen_reg;
    logic [15:0]        depth_reg;
    logic signed [15:0] cw0_reg, cw1_reg, cw2_reg;
    logic [15:0]        depth_next;
    side_t              sb_last;

    function automatic logic signed [15:0] sat_corr(
        input logic [QB-1:0] q,
        input logic          ov,
        input logic          neg,
        input logic          szero
    );
        logic big;
        logic [15:0] mag;
        big = ov | (q >= QB'(32768));
        mag = q[15:0];
        if (szero)
            sat_corr = 16'sd0;
        else if (big)
            sat_corr = neg ? 16'sh8000 : 16'sh7fff;
        else
            sat_corr = neg ? $signed(-mag) : $signed(mag);
    endfunction

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex0_reg <= '0;
            vertex1_reg <= '0;
            vertex2_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tcd_pkg::REG_VERTEX0: vertex0_reg <= cfg_data;
                tcd_pkg::REG_VERTEX1: vertex1_reg <= cfg_data;
                tcd_pkg::REG_VERTEX2: vertex2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    tcd_edge #(
        .SCREEN_BITS (SCREEN_BITS)
    ) u_edge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .vert0     (tcd_pkg::vert_t'(vertex0_reg)),
        .vert1     (tcd_pkg::vert_t'(vertex1_reg)),
        .vert2     (tcd_pkg::vert_t'(vertex2_reg)),
        .out_valid (edge_valid),
        .res       (edge_res)
    );

    tcd_weight u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (edge_valid),
        .res       (edge_res),
        .out_valid (div_valid),
        .dop       (dop)
    );

    tcd_div #(.NW(tcd_pkg::CNUM_W), .DW(tcd_pkg::DEN_W), .QB(QB)) u_div0 (
        .clk (clk), .num (dop.cnum0), .den (dop.den), .quo (q0), .ovf (o0)
    );

    tcd_div #(.NW(tcd_pkg::CNUM_W), .DW(tcd_pkg::DEN_W), .QB(QB)) u_div1 (
        .clk (clk), .num (dop.cnum1), .den (dop.den), .quo (q1), .ovf (o1)
    );

    tcd_div #(.NW(tcd_pkg::CNUM_W), .DW(tcd_pkg::DEN_W), .QB(QB)) u_div2 (
        .clk (clk), .num (dop.cnum2), .den (dop.den), .quo (q2), .ovf (o2)
    );

    tcd_div #(.NW(tcd_pkg::DNUM_W), .DW(tcd_pkg::DEN_W), .QB(QB)) u_divd (
        .clk (clk), .num (dop.dnum), .den (dop.den), .quo (qd), .ovf (od)
    );

    // Flags and valid bits ride beside the dividers with the same latency.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
                sb_reg[i] <= '0;
        end
        else
        begin
            sb_reg[0].valid <= div_valid;
            sb_reg[0].cov   <= dop.cov;
            sb_reg[0].degen <= dop.degen;
            sb_reg[0].szero <= dop.szero;
            sb_reg[0].cneg  <= dop.cneg;
            sb_reg[0].dneg  <= dop.dneg;
            for (int i = 1; i < DIV_LAT; i++)
                sb_reg[i] <= sb_reg[i-1];
        end
    end

    always_comb
    begin
        sb_last = sb_reg[DIV_LAT-1];
        // A negative depth clamps to zero, and so does an empty weighted sum.
        if (sb_last.szero || sb_last.dneg)
            depth_next = 16'd0;
        else if (od)
            depth_next = 16'hffff;
        else
            depth_next = qd[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= sb_last.valid;
    end

    always_ff @(posedge clk)
    begin
        covered_reg <= sb_last.cov;
        degen_reg   <= sb_last.degen;
        depth_reg   <= depth_next;
        cw0_reg     <= sat_corr(q0, o0, sb_last.cneg[0], sb_last.szero);
        cw1_reg     <= sat_corr(q1, o1, sb_last.cneg[1], sb_last.szero);
        cw2_reg     <= sat_corr(q2, o2, sb_last.cneg[2], sb_last.szero);
    end

    assign done         = done_reg;
    assign covered      = covered_reg;
    assign degenerate   = degen_reg;
    assign frag_depth   = depth_reg;
    assign corr_weight0 = cw0_reg;
    assign corr_weight1 = cw1_reg;
    assign corr_weight2 = cw2_reg;

endmodule

// ===== bench/triangle_coverage_depth_top_tb.sv =====
// Self-checking testbench for the triangle coverage and perspective-correct depth block.
`timescale 1ns / 1ps

module triangle_coverage_depth_top_tb;

    localparam int SCREEN_BITS = tcd_pkg::SCREEN_BITS_DEF;
    localparam int LATENCY = 26;

    typedef struct {
        logic [SCREEN_BITS-1:0] x;
        logic [SCREEN_BITS-1:0] y;
    } pixel_t;

    typedef struct {
        logic               covered;
        logic               degenerate;
        logic [15:0]        depth;
        logic signed [15:0] weight [3];
    } fragment_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    tcd_pkg::cfg_idx_t cfg_index;
    logic [63:0] cfg_data;
    logic start;
    logic busy;
    logic [SCREEN_BITS-1:0] pixel_x;
    logic [SCREEN_BITS-1:0] pixel_y;
    logic done;
    logic covered;
    logic degenerate;
    logic [15:0] frag_depth;
    logic signed [15:0] corr_weight0;
    logic signed [15:0] corr_weight1;
    logic signed [15:0] corr_weight2;

    triangle_coverage_depth_top #(.SCREEN_BITS(SCREEN_BITS)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .start(start), .busy(busy), .pixel_x(pixel_x), .pixel_y(pixel_y),
        .done(done), .covered(covered), .degenerate(degenerate),
        .frag_depth(frag_depth), .corr_weight0(corr_weight0),
        .corr_weight1(corr_weight1), .corr_weight2(corr_weight2)
    );

    tcd_pkg::vert_t vertex_shadow [3];
    pixel_t      pixel_q [$];
    fragment_t   fragment_q [$];
    int          errors = 0;
    int          pixels_sent = 0;
    int          fragments_seen = 0;
    int          covered_seen = 0;
    int          degenerate_seen = 0;
    int          config_writes = 0;
    int          gap_left = 0;
    bit          no_idle = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout at %0t", $time);
        $display("Mismatches found");
        $finish;
    end

    function automatic logic signed [15:0] sat_weight(logic signed [127:0] v);
        if (v > 32767)
            return 16'sh7FFF;
        else if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // Exact integer evaluation of the barycentric weights; the area cancels in every ratio.
    function automatic fragment_t shade_pixel(logic [SCREEN_BITS-1:0] col,
                                              logic [SCREEN_BITS-1:0] row);
        fragment_t f;
        longint vx [3];
        longint vy [3];
        longint wv [3];
        longint e [3];
        longint area;
        longint cx;
        longint cy;
        logic signed [127:0] t [3];
        logic signed [127:0] s;
        logic signed [127:0] num;
        logic signed [127:0] q;
        logic signed [127:0] tmp;
        for (int i = 0; i < 3; i++)
        begin
            vx[i] = longint'(vertex_shadow[i].x);
            vy[i] = longint'(vertex_shadow[i].y);
            wv[i] = (vertex_shadow[i].w == 16'd0) ? 64'sd1 : longint'(vertex_shadow[i].w);
        end
        cx = longint'(col) * 16 + 8;
        cy = longint'(row) * 16 + 8;
        area = (vx[1] - vx[0]) * (vy[2] - vy[0]) - (vy[1] - vy[0]) * (vx[2] - vx[0]);
        f.degenerate = (area == 0);
        if (f.degenerate)
        begin
            e[0] = 1;
            e[1] = 1;
            e[2] = 1;
            f.covered = 1'b1;
        end
        else
        begin
            e[0] = (vx[1] - cx) * (vy[2] - cy) - (vy[1] - cy) * (vx[2] - cx);
            e[1] = (vx[2] - cx) * (vy[0] - cy) - (vy[2] - cy) * (vx[0] - cx);
            e[2] = area - e[0] - e[1];
            if (area > 0)
                f.covered = (e[0] >= 0) && (e[1] >= 0) && (e[2] >= 0);
            else
                f.covered = (e[0] <= 0) && (e[1] <= 0) && (e[2] <= 0);
        end
        s = '0;
        num = '0;
        for (int i = 0; i < 3; i++)
        begin
            t[i] = 128'(e[i]);
            tmp = 128'(wv[(i + 1) % 3] * wv[(i + 2) % 3]);
            t[i] = t[i] * tmp;
            s = s + t[i];
            tmp = 128'(vertex_shadow[i].z);
            num = num + t[i] * tmp;
        end
        f.depth = 16'd0;
        for (int i = 0; i < 3; i++)
            f.weight[i] = 16'sd0;
        if (s != 0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                q = (t[i] <<< 14) / s;
                f.weight[i] = sat_weight(q);
            end
            q = num / s;
            if (q < 0)
                f.depth = 16'd0;
            else if (q > 65535)
                f.depth = 16'hFFFF;
            else
                f.depth = q[15:0];
        end
        return f;
    endfunction

    // Pixel driver: presents queued pixels with random gaps and predicts each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            pixel_x <= '0;
            pixel_y <= '0;
            gap_left = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                fragment_q.push_back(shade_pixel(pixel_x, pixel_y));
                pixels_sent++;
            end
            if (start && busy)
                ;
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pixel_q.size() > 0)
            begin
                pixel_t p;
                int r;
                p = pixel_q.pop_front();
                start <= 1'b1;
                pixel_x <= p.x;
                pixel_y <= p.y;
                r = $urandom_range(99);
                if (no_idle || r < 60)
                    gap_left = 0;
                else if (r < 90)
                    gap_left = $urandom_range(3, 1);
                else
                    gap_left = $urandom_range(40, 5);
            end
            else
                start <= 1'b0;
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (fragment_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got cov=%0b depth=%0h",
                         $time, covered, frag_depth);
                errors++;
            end
            else
            begin
                fragment_t f;
                f = fragment_q.pop_front();
                fragments_seen++;
                if (f.covered)
                    covered_seen++;
                if (f.degenerate)
                    degenerate_seen++;
                if (covered !== f.covered)
                begin
                    $display("%0t: covered expected %0b actual %0b", $time, f.covered, covered);
                    errors++;
                end
                if (degenerate !== f.degenerate)
                begin
                    $display("%0t: degenerate expected %0b actual %0b",
                             $time, f.degenerate, degenerate);
                    errors++;
                end
                if (frag_depth !== f.depth)
                begin
                    $display("%0t: frag_depth expected %0d actual %0d",
                             $time, f.depth, frag_depth);
                    errors++;
                end
                if (corr_weight0 !== f.weight[0])
                begin
                    $display("%0t: corr_weight0 expected %0d actual %0d",
                             $time, f.weight[0], corr_weight0);
                    errors++;
                end
                if (corr_weight1 !== f.weight[1])
                begin
                    $display("%0t: corr_weight1 expected %0d actual %0d",
                             $time, f.weight[1], corr_weight1);
                    errors++;
                end
                if (corr_weight2 !== f.weight[2])
                begin
                    $display("%0t: corr_weight2 expected %0d actual %0d",
                             $time, f.weight[2], corr_weight2);
                    errors++;
                end
            end
        end
    end

    // Writes all three vertices back to back; valid stays high across the burst.
    task automatic load_triangle(tcd_pkg::vert_t v0, tcd_pkg::vert_t v1, tcd_pkg::vert_t v2);
        tcd_pkg::vert_t vs [3];
        tcd_pkg::cfg_idx_t idx [3];
        vs[0] = v0;
        vs[1] = v1;
        vs[2] = v2;
        idx[0] = tcd_pkg::REG_VERTEX0;
        idx[1] = tcd_pkg::REG_VERTEX1;
        idx[2] = tcd_pkg::REG_VERTEX2;
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vs[i];
            forever
            begin
                @(posedge clk);
                if (cfg_ready)
                    break;
            end
            vertex_shadow[i] = vs[i];
            config_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    // Lets the pipeline drain before the vertex registers change.
    task automatic drain;
        while (pixel_q.size() > 0 || fragment_q.size() > 0 || start)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    function automatic tcd_pkg::vert_t make_vertex(int x, int y, int z, int w);
        tcd_pkg::vert_t v;
        v.x = 16'(x);
        v.y = 16'(y);
        v.z = 16'(z);
        v.w = 16'(w);
        return v;
    endfunction

    function automatic tcd_pkg::vert_t rand_vertex(int cx, int cy, int spread);
        tcd_pkg::vert_t v;
        int r;
        v.x = 16'(cx + int'($urandom_range(2 * spread)) - spread);
        v.y = 16'(cy + int'($urandom_range(2 * spread)) - spread);
        v.z = 16'($urandom());
        r = $urandom_range(9);
        v.w = (r == 0) ? 16'd0 : (r < 6) ? 16'($urandom_range(1024, 1)) : 16'($urandom());
        return v;
    endfunction

    task automatic add_pixel(int x, int y);
        pixel_t p;
        p.x = SCREEN_BITS'(x);
        p.y = SCREEN_BITS'(y);
        pixel_q.push_back(p);
    endtask

    initial
    begin
        tcd_pkg::vert_t v [3];
        int cx;
        int cy;
        int spread;
        int bx;
        int by;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = tcd_pkg::REG_VERTEX0;
        cfg_data = '0;
        for (int i = 0; i < 3; i++)
            vertex_shadow[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers still at reset: zero area and zero w everywhere.
        add_pixel(0, 0);
        add_pixel(2047, 2047);
        add_pixel(2047, 0);
        drain();

        // Counter-clockwise small triangle with pixels inside and outside it.
        load_triangle(make_vertex(16, 16, 0, 256), make_vertex(160, 16, 16'h8000, 512),
                      make_vertex(16, 160, 16'hFFFF, 0));
        add_pixel(2, 2);
        add_pixel(0, 0);
        add_pixel(9, 0);
        add_pixel(1, 1);
        add_pixel(20, 20);
        add_pixel(1500, 3);
        drain();

        // Same triangle wound the other way, extreme w.
        load_triangle(make_vertex(16, 16, 16'hFFFF, 16'hFFFF), make_vertex(16, 160, 0, 1),
                      make_vertex(160, 16, 1234, 16'h8000));
        add_pixel(2, 2);
        add_pixel(5, 5);
        add_pixel(12, 12);
        drain();

        // Vertices at three corners of the coordinate range.
        load_triangle(make_vertex(16'hFFFF, 16'hFFFF, 1, 3), make_vertex(0, 16'hFFFF, 2, 5),
                      make_vertex(16'hFFFF, 0, 16'hFFFF, 16'hFFFF));
        add_pixel(2047, 2047);
        add_pixel(1024, 1024);
        add_pixel(0, 2047);
        add_pixel(100, 1900);
        drain();

        // Collinear vertices on a diagonal line, not all at the origin.
        load_triangle(make_vertex(0, 0, 100, 7), make_vertex(320, 320, 200, 9),
                      make_vertex(640, 640, 300, 11));
        add_pixel(5, 5);
        add_pixel(1234, 17);
        drain();

        for (int phase = 0; phase < 18; phase++)
        begin
            no_idle = ($urandom_range(3) == 0);
            if (phase % 6 == 5)
            begin
                for (int i = 0; i < 3; i++)
                    v[i] = {$urandom(), $urandom()};
                cx = 1024;
                cy = 1024;
                spread = 1024;
            end
            else
            begin
                cx = $urandom_range(32760);
                cy = $urandom_range(32760);
                spread = ($urandom_range(3) == 0) ? 8000 : $urandom_range(800, 16);
                for (int i = 0; i < 3; i++)
                    v[i] = rand_vertex(cx, cy, spread);
                if (phase % 7 == 3)
                    v[2] = make_vertex(v[0].x, v[0].y, v[2].z, v[2].w);
            end
            load_triangle(v[0], v[1], v[2]);
            for (int k = 0; k < 45; k++)
            begin
                if ($urandom_range(3) == 0)
                    add_pixel($urandom(), $urandom());
                else
                begin
                    bx = (int'(v[$urandom_range(2)].x) >> 4) + $urandom_range(2 * spread / 16 + 2)
                         - spread / 16 - 1;
                    by = (int'(v[$urandom_range(2)].y) >> 4) + $urandom_range(2 * spread / 16 + 2)
                         - spread / 16 - 1;
                    add_pixel(bx, by);
                end
            end
            drain();
        end

        $display("Checked %0d pixels (%0d results, %0d covered, %0d degenerate)",
                 pixels_sent, fragments_seen, covered_seen, degenerate_seen);
        $display("over %0d vertex register writes.", config_writes);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
